[src/selective_reject_reorder_receiver_assert.svh]
// Assertion macros for the port checker of the reorder receiver.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SELECTIVE_REJECT_REORDER_RECEIVER_ASSERT_SVH
`define SELECTIVE_REJECT_REORDER_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define SRR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/srr_pkg.sv]
// Shared types and constants of the selective-reject reorder receiver.
// No dependencies.
package srr_pkg;

	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_RR      = 2'd1,
		KIND_SREJ    = 2'd2,
		KIND_START   = 2'd3
	} kind_t;

	localparam int SEQ_BITS = 32;
	localparam int REF_BITS = 16;
	localparam int WREQ_BITS = 5;

endpackage

[src/srr_if.sv]
// Valid/ready channel interfaces for packet descriptors and result items.
// Depends on srr_pkg.
interface srr_in_if #(parameter int LEN_BITS = 11);
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic                        checksum_ok;
	logic [srr_pkg::SEQ_BITS-1:0]  seq_num;
	logic [srr_pkg::WREQ_BITS-1:0] window_req;
	logic [srr_pkg::REF_BITS-1:0]  payload_ref;
	logic [LEN_BITS-1:0]           payload_len;

	modport source (output valid, func, checksum_ok, seq_num, window_req, payload_ref,
		payload_len, input ready);
	modport sink (input valid, func, checksum_ok, seq_num, window_req, payload_ref,
		payload_len, output ready);
endinterface

interface srr_out_if #(parameter int LEN_BITS = 11);
	logic                         valid;
	logic                         ready;
	srr_pkg::kind_t               kind;
	logic [srr_pkg::SEQ_BITS-1:0] number;
	logic [srr_pkg::REF_BITS-1:0] out_ref;
	logic [LEN_BITS-1:0]          out_len;
	logic                         last;

	modport source (output valid, kind, number, out_ref, out_len, last, input ready);
	modport sink (input valid, kind, number, out_ref, out_len, last, output ready);
endinterface

[src/selective_reject_reorder_receiver.sv]
// Selective-reject reorder receiver: top level with control sequencer.
// Depends on srr_pkg, srr_if (srr_in_if, srr_out_if) and srr_ram.
//
//   channel  role  carries
//   rx       sink  packet descriptors (func, checksum_ok, seq_num, window_req, ref, len)
//   tx       src   results (kind, number, out_ref, out_len, last)
//
// An item is taken in S_IDLE and evaluated in S_EVAL in the next cycle. After an in-order
// delivery, or an old packet while buffering, each held packet flushed takes a read of the
// slot memory (S_RD) and a check (S_CHK). The probe that ends the run is a read and a
// check, or S_RD alone at the window limit. Then RR follows, and SREJ while a gap is open.
// Reset clears the sequencer, the valid bits and the sequence state at once;
// the slot memory itself is never cleared. A stalled tx holds the sequencer.
module selective_reject_reorder_receiver #(
	parameter int WINDOW_MAX = 16,
	parameter int LEN_BITS = 11
) (
	input logic clk,
	input logic arst_n,
	srr_in_if.sink   rx,
	srr_out_if.source tx
);
	import srr_pkg::*;

	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int WW = $clog2(WINDOW_MAX + 1);
	localparam int W_RST = (WINDOW_MAX < 16) ? WINDOW_MAX : 16;
	localparam int DW = SEQ_BITS + REF_BITS + LEN_BITS;

	typedef enum logic [2:0] {S_IDLE, S_EVAL, S_RD, S_CHK, S_RR, S_SREJ} state_t;

	state_t state_q;

	// Captured descriptor.
	logic                  func_q, ok_q;
	logic [SEQ_BITS-1:0]   seq_q;
	logic [WREQ_BITS-1:0]  wreq_q;
	logic [REF_BITS-1:0]   ref_q;
	logic [LEN_BITS-1:0]   len_q;

	// Receiver state.
	logic [SEQ_BITS-1:0]   exp_q, high_q;
	logic                  mode_q;
	logic [WW-1:0]         win_q;
	logic [IW-1:0]         exp_idx_q;   // expected_seq modulo the window
	logic [WW-1:0]         cnt_q;       // flush steps taken
	logic [WINDOW_MAX-1:0] valid_q;

	// Output register.
	logic                  ov_q;
	kind_t                 kind_q;
	logic [SEQ_BITS-1:0]   num_q;
	logic [REF_BITS-1:0]   oref_q;
	logic [LEN_BITS-1:0]   olen_q;
	logic                  last_q;

	logic                  can_emit;
	logic                  ov_load;
	logic [SEQ_BITS-1:0]   diff, exp_inc;
	logic                  seq_gt, seq_eq, in_win;
	logic [WW:0]           idx_sum, idx_wrap, inc_sum;
	logic [IW-1:0]         slot_idx, exp_idx_inc;
	logic [5:0]            wreq_ext;
	logic [WW-1:0]         win_start;
	logic [IW-1:0]         idx_start;
	logic                  ram_we, ram_re;
	logic [DW-1:0]         ram_rdata;
	logic [SEQ_BITS-1:0]   rd_seq;
	logic                  hit;

	assign rx.ready = (state_q == S_IDLE);
	assign tx.valid = ov_q;
	assign tx.kind = kind_q;
	assign tx.number = num_q;
	assign tx.out_ref = oref_q;
	assign tx.out_len = olen_q;
	assign tx.last = last_q;

	// A result can be loaded when the output register is empty or drains now.
	assign can_emit = !ov_q || tx.ready;

	assign diff = seq_q - exp_q;
	assign seq_gt = seq_q > exp_q;
	assign seq_eq = seq_q == exp_q;
	assign in_win = diff < SEQ_BITS'(win_q);
	assign exp_inc = exp_q + 32'd1;

	// The sequencer loads a new result into the output register in these cycles.
	assign ov_load = ((state_q == S_EVAL) && ok_q && can_emit
			&& (func_q || (seq_gt && in_win && !mode_q) || seq_eq))
		|| ((state_q == S_CHK) && hit && can_emit)
		|| (((state_q == S_RR) || (state_q == S_SREJ)) && can_emit);

	// Slot of a packet inside the window: exp_idx plus the distance, wrapped once.
	assign idx_sum = (WW + 1)'(exp_idx_q) + (WW + 1)'(diff[WW-1:0]);
	assign idx_wrap = (idx_sum >= (WW + 1)'(win_q)) ? idx_sum - (WW + 1)'(win_q) : idx_sum;
	assign slot_idx = idx_wrap[IW-1:0];

	assign inc_sum = (WW + 1)'(exp_idx_q) + (WW + 1)'(1);
	assign exp_idx_inc = (inc_sum == (WW + 1)'(win_q)) ? '0 : inc_sum[IW-1:0];

	// Start item: window request clamped to 1..WINDOW_MAX.
	assign wreq_ext = 6'(wreq_q);
	always_comb begin
		priority if (wreq_ext == 6'd0) begin
			win_start = WW'(1);
		end else if (wreq_ext > 6'(WINDOW_MAX)) begin
			win_start = WW'(WINDOW_MAX);
		end else begin
			win_start = wreq_ext[WW-1:0];
		end
	end
	assign idx_start = (win_start == WW'(1)) ? '0 : IW'(1);

	assign ram_we = (state_q == S_EVAL) && ok_q && !func_q && seq_gt && in_win
		&& (mode_q || can_emit);
	assign ram_re = (state_q == S_RD) && (cnt_q < win_q - WW'(1));

	srr_ram #(.WIDTH(DW), .DEPTH(WINDOW_MAX)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_idx),
		.wdata ({seq_q, ref_q, len_q}),
		.re    (ram_re),
		.raddr (exp_idx_q),
		.rdata (ram_rdata)
	);

	assign rd_seq = ram_rdata[DW-1 -: SEQ_BITS];
	assign hit = valid_q[exp_idx_q] && (rd_seq == exp_q);

	// The output register fills on a load and empties when its item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ov_load) begin
			ov_q <= 1'b1;
		end else if (tx.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			exp_q <= 32'd1;
			high_q <= '0;
			mode_q <= 1'b0;
			win_q <= WW'(W_RST);
			exp_idx_q <= (W_RST == 1) ? '0 : IW'(1);
			cnt_q <= '0;
			valid_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (rx.valid) begin
						func_q <= rx.func;
						ok_q <= rx.checksum_ok;
						seq_q <= rx.seq_num;
						wreq_q <= rx.window_req;
						ref_q <= rx.payload_ref;
						len_q <= rx.payload_len;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!ok_q) begin
						state_q <= S_IDLE;
					end else if (func_q) begin
						if (can_emit) begin
							win_q <= win_start;
							exp_idx_q <= idx_start;
							valid_q <= '0;
							exp_q <= 32'd1;
							high_q <= '0;
							mode_q <= 1'b0;
							kind_q <= KIND_START;
							num_q <= '0;
							oref_q <= '0;
							olen_q <= '0;
							last_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (seq_gt) begin
						if (!in_win) begin
							state_q <= S_IDLE;
						end else if (mode_q || can_emit) begin
							valid_q[slot_idx] <= 1'b1;
							if (seq_q > high_q) begin
								high_q <= seq_q;
							end
							if (!mode_q) begin
								mode_q <= 1'b1;
								kind_q <= KIND_SREJ;
								num_q <= exp_q;
								oref_q <= '0;
								olen_q <= '0;
								last_q <= 1'b1;
							end
							state_q <= S_IDLE;
						end
					end else if (seq_eq) begin
						if (can_emit) begin
							kind_q <= KIND_DELIVER;
							num_q <= seq_q;
							oref_q <= ref_q;
							olen_q <= len_q;
							last_q <= 1'b0;
							if (seq_q > high_q) begin
								high_q <= seq_q;
							end
							exp_q <= exp_inc;
							exp_idx_q <= exp_idx_inc;
							cnt_q <= '0;
							state_q <= S_RD;
						end
					end else if (!mode_q) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= ram_re ? S_CHK : S_RR;
				end
				S_CHK: begin
					if (!hit) begin
						state_q <= S_RR;
					end else if (can_emit) begin
						kind_q <= KIND_DELIVER;
						num_q <= exp_q;
						oref_q <= ram_rdata[LEN_BITS +: REF_BITS];
						olen_q <= ram_rdata[LEN_BITS-1:0];
						last_q <= 1'b0;
						valid_q[exp_idx_q] <= 1'b0;
						exp_q <= exp_inc;
						exp_idx_q <= exp_idx_inc;
						cnt_q <= cnt_q + WW'(1);
						state_q <= S_RD;
					end
				end
				S_RR: begin
					if (can_emit) begin
						kind_q <= KIND_RR;
						num_q <= exp_q - 32'd1;
						oref_q <= '0;
						olen_q <= '0;
						// A gap still open keeps buffering and is followed by an SREJ.
						if (high_q >= exp_q) begin
							mode_q <= 1'b1;
							last_q <= 1'b0;
							state_q <= S_SREJ;
						end else begin
							mode_q <= 1'b0;
							last_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_SREJ: begin
					if (can_emit) begin
						kind_q <= KIND_SREJ;
						num_q <= exp_q;
						oref_q <= '0;
						olen_q <= '0;
						last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[src/srr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[src/srr_checker.sv]
// Port-level checker for the reorder receiver, bound to the top level.
// Depends on srr_pkg and selective_reject_reorder_receiver_assert.svh.
module srr_port_checker #(
	parameter int LEN_BITS = 11
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input srr_pkg::kind_t               kind,
	input logic [srr_pkg::SEQ_BITS-1:0] number,
	input logic [srr_pkg::REF_BITS-1:0] out_ref,
	input logic [LEN_BITS-1:0]          out_len,
	input logic                         last
);
	import srr_pkg::*;

`include "selective_reject_reorder_receiver_assert.svh"

	// One item at a time: the block is busy right after taking an item.
	`SRR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	// A stalled result stays valid and holds its number and last flag.
	`SRR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(number) && $stable(last), "stalled result changed")
	// Only deliveries carry a payload handle.
	`SRR_ASSERT_NOW(a_no_payload, out_valid && kind != KIND_DELIVER, out_ref == '0 && out_len == '0, "payload on control result")
	// An SREJ always closes the results of its item.
	`SRR_ASSERT_NOW(a_srej_last, out_valid && kind == KIND_SREJ, last, "SREJ not last")
endmodule

bind selective_reject_reorder_receiver srr_port_checker #(.LEN_BITS(LEN_BITS)) u_srr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (rx.valid),
	.in_ready  (rx.ready),
	.out_valid (tx.valid),
	.out_ready (tx.ready),
	.kind      (tx.kind),
	.number    (tx.number),
	.out_ref   (tx.out_ref),
	.out_len   (tx.out_len),
	.last      (tx.last)
);

[test/srr_checker.sv]
// Scoreboard for the selective-reject reorder receiver: predicts results from accepted
// descriptors and compares them with the result channel. Depends on srr_pkg and srr_if.
module srr_checker #(
	parameter int WINDOW_MAX = 16,
	parameter int LEN_BITS = 11
) (
	input logic clk,
	input logic arst_n,
	srr_in_if   rx,
	srr_out_if  tx,
	output int  errors,
	output int  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import srr_pkg::*;

	typedef struct {
		kind_t               kind;
		logic [31:0]         number;
		logic [15:0]         pref;
		logic [LEN_BITS-1:0] plen;
		logic                last;
	} answer_t;

	answer_t awaited[$];

	// Receiver state as the block should hold it.
	logic [31:0]         held_seq [WINDOW_MAX];
	logic [15:0]         held_ref [WINDOW_MAX];
	logic [LEN_BITS-1:0] held_len [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] held_ok;
	logic [31:0] next_seq;
	logic [31:0] top_seq;
	logic        buffering;
	int          win;

	assign pending = awaited.size();

	task automatic add(ref answer_t batch[$], input kind_t k, input logic [31:0] num,
		input logic [15:0] r, input logic [LEN_BITS-1:0] l);
		answer_t a;
		a.kind = k;
		a.number = num;
		a.pref = r;
		a.plen = l;
		a.last = 1'b0;
		batch.push_back(a);
	endtask

	task automatic take_descriptor(input logic f, input logic ok, input logic [31:0] s,
		input logic [4:0] wr, input logic [15:0] r, input logic [LEN_BITS-1:0] l);
		answer_t batch[$];
		int w;
		int idx;
		if (!ok)
			return;
		if (f) begin
			w = wr;
			if (w < 1) w = 1;
			if (w > WINDOW_MAX) w = WINDOW_MAX;
			win = w;
			held_ok = '0;
			next_seq = 1;
			top_seq = 0;
			buffering = 1'b0;
			add(batch, KIND_START, 0, 0, 0);
		end else begin
			w = win;
			if (w < 1) w = 1;
			if (w > WINDOW_MAX) w = WINDOW_MAX;
			if (s > next_seq) begin
				// Ahead of the expected number: hold it unless it falls outside the window.
				if (s - next_seq >= w)
					return;
				idx = s % w;
				held_seq[idx] = s;
				held_ref[idx] = r;
				held_len[idx] = l;
				held_ok[idx] = 1'b1;
				if (s > top_seq) top_seq = s;
				if (!buffering) begin
					buffering = 1'b1;
					add(batch, KIND_SREJ, next_seq, 0, 0);
				end
			end else begin
				if (s == next_seq) begin
					add(batch, KIND_DELIVER, s, r, l);
					if (s > top_seq) top_seq = s;
					next_seq = next_seq + 1;
				end else if (!buffering) begin
					return;
				end
				// Flush the held run that continues the sequence.
				for (int i = 0; i + 1 < w; i++) begin
					idx = next_seq % w;
					if (!held_ok[idx] || held_seq[idx] != next_seq)
						break;
					add(batch, KIND_DELIVER, next_seq, held_ref[idx], held_len[idx]);
					held_ok[idx] = 1'b0;
					next_seq = next_seq + 1;
				end
				add(batch, KIND_RR, next_seq - 1, 0, 0);
				if (top_seq >= next_seq) begin
					buffering = 1'b1;
					add(batch, KIND_SREJ, next_seq, 0, 0);
				end else begin
					buffering = 1'b0;
				end
			end
		end
		if (batch.size() == 0)
			return;
		batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			awaited.push_back(batch[i]);
	endtask

	function automatic int differs(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		int bad;
		if (!arst_n) begin
			awaited.delete();
			held_ok = '0;
			next_seq = 1;
			top_seq = 0;
			buffering = 1'b0;
			win = (WINDOW_MAX < 16) ? WINDOW_MAX : 16;
			errors <= 0;
		end else begin
			bad = 0;
			if (tx.valid && tx.ready) begin
				if (awaited.size() == 0) begin
					$error("unexpected result item: kind %0d number %0h", tx.kind, tx.number);
					bad++;
				end else begin
					a = awaited.pop_front();
					bad += differs("kind", a.kind, tx.kind);
					bad += differs("number", a.number, tx.number);
					bad += differs("out_ref", a.pref, tx.out_ref);
					bad += differs("out_len", a.plen, tx.out_len);
					bad += differs("last", a.last, tx.last);
				end
			end
			if (rx.valid && rx.ready)
				take_descriptor(rx.func, rx.checksum_ok, rx.seq_num, rx.window_req,
					rx.payload_ref, rx.payload_len);
			errors <= errors + bad;
		end
	end
endmodule

[test/tb_selective_reject_reorder_receiver.sv]
// Testbench top for the selective-reject reorder receiver: clock, reset, descriptor
// stimulus and verdict. Depends on srr_pkg, srr_if, the block and srr_checker.
module tb_selective_reject_reorder_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WMAX = 16;
	localparam int LBITS = 11;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	int   errors;
	int   pending;
	int   sent = 0;

	srr_in_if  #(.LEN_BITS(LBITS)) rx_ch ();
	srr_out_if #(.LEN_BITS(LBITS)) tx_ch ();

	selective_reject_reorder_receiver #(.WINDOW_MAX(WMAX), .LEN_BITS(LBITS)) uut (
		.clk(clk), .arst_n(arst_n), .rx(rx_ch), .tx(tx_ch)
	);

	srr_checker #(.WINDOW_MAX(WMAX), .LEN_BITS(LBITS)) scoreboard (
		.clk(clk), .arst_n(arst_n), .rx(rx_ch), .tx(tx_ch),
		.errors(errors), .pending(pending)
	);

	always #2 clk = ~clk;

	// The result side stalls about a third of the time, except during the calm stretch.
	always @(posedge clk)
		tx_ch.ready <= calm || ($urandom_range(99) >= 35);

	// Offers one descriptor, possibly after a random gap, and returns at the edge where
	// it was taken. Ready is sampled at the falling edge, well clear of the rising one.
	task automatic offer(input logic f, input logic ok, input logic [31:0] s,
		input logic [4:0] wr, input logic [15:0] r, input logic [LBITS-1:0] l);
		logic took;
		if (!calm && $urandom_range(99) < 35) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.func <= f;
		rx_ch.checksum_ok <= ok;
		rx_ch.seq_num <= s;
		rx_ch.window_req <= wr;
		rx_ch.payload_ref <= r;
		rx_ch.payload_len <= l;
		sent++;
		do begin
			@(negedge clk);
			took = rx_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic data(input logic [31:0] s);
		offer(1'b0, 1'b1, s, 5'($urandom), 16'($urandom), LBITS'($urandom));
	endtask

	task automatic open_transfer(input logic [4:0] wr);
		offer(1'b1, 1'b1, $urandom, wr, 16'($urandom), LBITS'($urandom));
	endtask

	task automatic drain;
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [31:0] order[$];
		logic [31:0] t;
		int w;
		int n;
		int j;
		rx_ch.valid = 1'b0;
		rx_ch.func = 1'b0;
		rx_ch.checksum_ok = 1'b0;
		rx_ch.seq_num = '0;
		rx_ch.window_req = '0;
		rx_ch.payload_ref = '0;
		rx_ch.payload_len = '0;
		tx_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Bad checksums are dropped for data and start alike.
		offer(1'b0, 1'b0, 32'd1, 5'd3, 16'hFFFF, '1);
		offer(1'b1, 1'b0, 32'd0, 5'd2, 16'h0000, '0);
		// Default window: in-order delivery with extreme payload fields.
		offer(1'b0, 1'b1, 32'd1, 5'd31, 16'hFFFF, '1);
		offer(1'b0, 1'b1, 32'd2, 5'd0, 16'h0000, '0);
		// Old packet while in order is ignored; far ahead is outside the window.
		data(1);
		data(32'hFFFF_FFFF);
		// Gap opens buffering, a copy overwrites the slot, an old one re-sends RR and SREJ.
		data(4);
		data(4);
		data(5);
		data(2);
		data(3);
		// Window request above the maximum is clamped; the flush leaves a gap behind.
		open_transfer(5'd31);
		data(2);
		data(4);
		data(1);
		data(3);
		// Smallest window from a zero request: only the expected number fits.
		open_transfer(5'd0);
		data(2);
		data(1);
		// Full window of sixteen: a complete held run in reverse order.
		open_transfer(5'd16);
		for (int s = 16; s >= 1; s--) data(s);
		drain();

		// Random part: shuffled sequences within the window, with noise mixed in.
		while (sent < 120) begin
			calm = (sent >= 75 && sent < 105);
			w = $urandom_range(1, 16);
			if ($urandom_range(9) == 0) w = $urandom_range(0, 31);
			open_transfer(5'(w));
			if (w < 1) w = 1;
			if (w > WMAX) w = WMAX;
			n = $urandom_range(3, 20);
			order.delete();
			for (int s = 1; s <= n; s++) order.push_back(s);
			if (w > 1) begin
				for (int k = 0; k < n / 2; k++) begin
					int i;
					i = $urandom_range(0, n - 2);
					j = i + $urandom_range(1, w - 1);
					if (j < n) begin
						t = order[i];
						order[i] = order[j];
						order[j] = t;
					end
				end
			end
			foreach (order[k]) begin
				case ($urandom_range(19))
					0: offer(1'($urandom), 1'($urandom), $urandom, 5'($urandom),
						16'($urandom), LBITS'($urandom));
					1: offer(1'b0, 1'b0, order[k], 5'($urandom), 16'($urandom),
						LBITS'($urandom));
					2: data(order[$urandom_range(0, k)]);
					default: ;
				endcase
				data(order[k]);
			end
			// In the middle stretch, hold off after each transfer until every result has come.
			if (sent >= 60 && sent < 90)
				drain();
		end
		calm = 1'b0;
		drain();
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
